[sv/dbcr_pkg.sv]
// Package for the double-byte character remapper.
// Holds the queue entry type, item kinds and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dbcr_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QDepth  = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBaseCode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLeadMin  = 2'd1;

  localparam logic [7:0] BaseCodeRst = 8'd128;
  localparam logic [7:0] LeadMinRst  = 8'hA1;

  // What the back end has to do with one queued input.
  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_TWO,
    KIND_PAIR
  } item_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        last;
  } q_entry_t;

endpackage

`default_nettype wire

[sv/dbcr_if.sv]
// Stream and configuration interfaces of the double-byte character remapper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface dbcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_last;

  modport source (output valid, in_byte, line_last, input ready);
  modport sink   (input valid, in_byte, line_last, output ready);
endinterface

interface dbcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       line_end;
  logic       run_last;
  logic [6:0] distinct_count;
  logic       table_overflow;

  modport source (output valid, out_byte, line_end, run_last, distinct_count, table_overflow,
                  input ready);
  modport sink   (input valid, out_byte, line_end, run_last, distinct_count, table_overflow,
                  output ready);
endinterface

interface dbcr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/dbcr_front.sv]
// Front end: accepts input bytes, holds a possible lead byte and classifies.
// Depends on dbcr_pkg and dbcr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module dbcr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        lead_min_i,
  dbcr_in_if.sink           in_i,
  input  logic              q_ready_i,
  output logic              q_push_o,
  output dbcr_pkg::q_entry_t q_entry_o
);
  import dbcr_pkg::*;

  logic       held_q;
  logic [7:0] held_byte_q;
  logic       accept;
  logic       lead;
  logic       hold_new;

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid && q_ready_i;
  assign lead       = (in_i.in_byte >= lead_min_i);
  // A lead byte that does not end its line waits for its partner.
  assign hold_new   = !held_q && lead && !in_i.line_last;
  assign q_push_o   = accept && !hold_new;

  always_comb begin
    q_entry_o.b1   = in_i.in_byte;
    q_entry_o.last = in_i.line_last;
    if (held_q) begin
      q_entry_o.kind = lead ? KIND_PAIR : KIND_TWO;
      q_entry_o.b0   = held_byte_q;
    end else begin
      q_entry_o.kind = KIND_SINGLE;
      q_entry_o.b0   = in_i.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      held_byte_q <= '0;
    end else if (accept) begin
      held_q <= hold_new;
      if (hold_new) begin
        held_byte_q <= in_i.in_byte;
      end
    end
  end

endmodule

`default_nettype wire

[sv/dbcr_queue.sv]
// Short queue between the front and the back end.
// Depends on dbcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbcr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dbcr_pkg::q_entry_t entry_i,
  output logic               ready_o,
  output logic               valid_o,
  output dbcr_pkg::q_entry_t head_o,
  input  logic               pop_i
);
  import dbcr_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  q_entry_t            mem_q [QDepth];
  logic [PtrW-1:0]     wr_ptr_q;
  logic [PtrW-1:0]     rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign ready_o = (count_q != CntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/dbcr_back.sv]
// Back end: character table lookup, code assignment and the output register.
// Depends on dbcr_pkg and dbcr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module dbcr_back #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         base_code_i,
  input  logic               q_valid_i,
  input  dbcr_pkg::q_entry_t q_head_i,
  output logic               q_pop_o,
  dbcr_out_if.source         out_o
);
  import dbcr_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESOLVE,
    S_EMIT
  } state_e;

  state_e                  state_q;
  logic [7:0]              w_b0_q;
  logic [7:0]              w_b1_q;
  logic                    w_last_q;
  logic                    w_two_q;
  logic                    slot_q;
  logic [CntW-1:0]         count_q;
  logic                    ovf_q;

  logic                    out_valid_q;
  logic [7:0]              out_byte_q;
  logic                    out_end_q;
  logic                    out_last_q;
  logic [6:0]              out_cnt_q;
  logic                    out_ovf_q;

  // Table cells: each compares its own entry against the broadcast key.
  logic [15:0]             cell_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] match_d;
  logic [TABLE_ENTRIES-1:0] match_q;

  logic                    out_load_ok;
  logic                    emit_fire;
  logic                    emit_final;
  logic [15:0]             head_key;
  logic                    hit;
  logic [IdxW-1:0]         hit_idx;
  logic                    table_full;
  logic                    store_new;
  logic [IdxW-1:0]         slot_idx;
  logic [9:0]              code_base;
  logic                    map_ok;
  logic [7:0]              code0;
  logic [7:0]              cnt8;
  logic [6:0]              cnt_sat;

  assign out_load_ok = !out_valid_q || out_o.ready;
  assign emit_fire   = (state_q == S_EMIT) && out_load_ok;
  assign emit_final  = emit_fire && (!w_two_q || slot_q);
  assign q_pop_o     = q_valid_i && ((state_q == S_IDLE) || emit_final);
  assign head_key    = {q_head_i.b0, q_head_i.b1};

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_d[i] = (CntW'(i) < count_q) && (cell_q[i] == head_key);
    end
  end

  // Stored characters are distinct, so at most one cell matches.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match_q[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end
  end

  assign hit        = |match_q;
  assign table_full = (count_q == CntW'(TABLE_ENTRIES));
  assign store_new  = !hit && !table_full;
  assign slot_idx   = hit ? hit_idx : count_q[IdxW-1:0];
  assign code_base  = 10'(base_code_i) + 10'({slot_idx, 1'b0});
  // The second code must still fit in a byte.
  assign map_ok     = (hit || store_new) && (code_base < 10'd255);
  assign code0      = code_base[7:0];

  assign cnt8    = 8'(count_q);
  assign cnt_sat = (cnt8 > 8'd127) ? 7'd127 : cnt8[6:0];

  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.line_end       = out_end_q;
  assign out_o.run_last       = out_last_q;
  assign out_o.distinct_count = out_cnt_q;
  assign out_o.table_overflow = out_ovf_q;

  always_ff @(posedge clk_i) begin
    if ((state_q == S_RESOLVE) && store_new) begin
      cell_q[count_q[IdxW-1:0]] <= {w_b0_q, w_b1_q};
    end
    if (q_pop_o) begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      w_b0_q      <= '0;
      w_b1_q      <= '0;
      w_last_q    <= 1'b0;
      w_two_q     <= 1'b0;
      slot_q      <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_end_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_cnt_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (out_load_ok) begin
        out_valid_q <= (state_q == S_EMIT);
      end
      if (emit_fire) begin
        out_byte_q <= (w_two_q && slot_q) ? w_b1_q : w_b0_q;
        out_end_q  <= (!w_two_q || slot_q) && w_last_q;
        out_last_q <= !w_two_q || slot_q;
        out_cnt_q  <= cnt_sat;
        out_ovf_q  <= ovf_q;
      end

      // A new entry starts on its first byte; otherwise an emitted byte moves on.
      if (q_pop_o) begin
        slot_q <= 1'b0;
      end else if (emit_fire) begin
        slot_q <= 1'b1;
      end

      case (state_q)
        S_RESOLVE: begin
          if (store_new) begin
            count_q <= count_q + 1'b1;
          end
          if (map_ok) begin
            w_b0_q <= code0;
            w_b1_q <= code0 + 8'd1;
          end else begin
            ovf_q <= 1'b1;
          end
          state_q <= S_EMIT;
        end
        S_IDLE, S_EMIT: begin
          if (q_pop_o) begin
            w_b0_q   <= q_head_i.b0;
            w_b1_q   <= q_head_i.b1;
            w_last_q <= q_head_i.last;
            w_two_q  <= (q_head_i.kind != KIND_SINGLE);
            state_q  <= (q_head_i.kind == KIND_PAIR) ? S_RESOLVE : S_EMIT;
          end else if (emit_final) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/double_byte_char_remapper.sv]
// Top level of the double-byte character remapper: configuration registers
// and the front end, queue and back end. Depends on dbcr_pkg, dbcr_if,
// dbcr_front, dbcr_queue and dbcr_back.
//
// Usage: bytes of text enter on in_i, each with line_last marking the end of
// its line. Two adjacent lead bytes of one line form a character that is
// looked up in a table of distinct characters and replaced by the codes
// base_code+2k and base_code+2k+1. Every other byte passes through. Each
// transfer on out_o carries one byte with the table count and the sticky
// overflow flag; run_last marks the last byte caused by one input transfer.
// cfg_i writes base_code (index 0) and lead_min (index 1); other indexes are
// ignored. It is always ready; the user must write it only while the block
// is idle, as the block does not enforce this. A pair also passes the table
// lookup, which compares the key against all stored cells as the entry
// leaves the queue, registers the matches and resolves the slot from them.
// Throughput: one input transfer per cycle for plain bytes while out_o does
// not stall; a pair holds the back end in RESOLVE and in EMIT for each byte.
// Reset clears the held byte, the queue, the table count, the overflow flag
// and the output register; table contents are only read once written.
// When out_o stalls, the output register holds its transfer, the back end
// waits and the two-entry queue fills before in_i drops ready.
`timescale 1ns / 1ps
`default_nettype none

module double_byte_char_remapper #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dbcr_in_if.sink      in_i,
  dbcr_out_if.source   out_o,
  dbcr_cfg_if.sink     cfg_i
);
  import dbcr_pkg::*;

  logic [7:0] base_code_q;
  logic [7:0] lead_min_q;

  logic       q_push;
  logic       q_ready;
  logic       q_valid;
  logic       q_pop;
  q_entry_t   q_entry;
  q_entry_t   q_head;

  // The configuration port never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_code_q <= BaseCodeRst;
      lead_min_q  <= LeadMinRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgBaseCode: base_code_q <= cfg_i.data;
        CfgLeadMin:  lead_min_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // The front end holds a lone lead byte and queues one entry per input
  // that produces results.
  dbcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lead_min_i (lead_min_q),
    .in_i       (in_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  dbcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  // The back end owns the character table and the output register.
  dbcr_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_code_i (base_code_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[dv/dbcr_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the double-byte character remapper: watches the input, output and
// configuration transfers, predicts every output byte and compares it field by field.
// Depends on dbcr_pkg and dbcr_if.

module dbcr_checker
  import dbcr_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbcr_in_if          in_mon_i,
  dbcr_out_if         out_mon_i,
  dbcr_cfg_if         cfg_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_end;
    logic       run_last;
    logic [6:0] distinct_count;
    logic       table_overflow;
  } remap_byte_t;

  remap_byte_t expected_bytes[$];

  logic [7:0]  base_code;
  logic [7:0]  lead_min;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic [15:0] char_table [TABLE_ENTRIES];
  int unsigned char_count;
  logic        overflow_seen;
  int unsigned fails;

  function automatic remap_byte_t result_of(input logic [7:0] b, input logic line_end,
                                            input logic run_last);
    remap_byte_t r;
    r.out_byte       = b;
    r.line_end       = line_end;
    r.run_last       = run_last;
    r.distinct_count = (char_count > 127) ? 7'd127 : char_count[6:0];
    r.table_overflow = overflow_seen;
    return r;
  endfunction

  // Finds or stores the character and returns 1 with its two codes, or 0 when the
  // pair has to pass through unchanged.
  function automatic bit assign_codes(input logic [7:0] hi, input logic [7:0] lo,
                                      output logic [7:0] c0, output logic [7:0] c1);
    logic [15:0] key;
    int unsigned slot;
    int unsigned code;
    key  = {hi, lo};
    slot = char_count;
    c0   = hi;
    c1   = lo;
    for (int unsigned k = 0; k < char_count && slot == char_count; k++) begin
      if (char_table[k] == key) slot = k;
    end
    if (slot == char_count) begin
      if (char_count >= TABLE_ENTRIES) begin
        overflow_seen = 1'b1;
        return 1'b0;
      end
      char_table[char_count] = key;
      char_count++;
    end
    code = base_code + 2 * slot;
    if (code + 1 > 255) begin
      overflow_seen = 1'b1;
      return 1'b0;
    end
    c0 = code[7:0];
    c1 = code[7:0] + 8'd1;
    return 1'b1;
  endfunction

  function automatic void predict_input(input logic [7:0] b, input logic last);
    logic [7:0] head;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] m0;
    logic [7:0] m1;
    logic       lead;
    lead = (b >= lead_min);
    if (held_valid) begin
      head       = held_byte;
      held_valid = 1'b0;
      held_byte  = '0;
      c0 = head;
      c1 = b;
      if (lead && assign_codes(head, b, m0, m1)) begin
        c0 = m0;
        c1 = m1;
      end
      expected_bytes.push_back(result_of(c0, 1'b0, 1'b0));
      expected_bytes.push_back(result_of(c1, last, 1'b1));
    end else if (lead && !last) begin
      held_byte  = b;
      held_valid = 1'b1;
    end else begin
      expected_bytes.push_back(result_of(b, last, 1'b1));
    end
  endfunction

  function automatic void report(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fails++;
  endfunction

  function automatic void check_byte(input remap_byte_t want);
    if (out_mon_i.out_byte !== want.out_byte)
      report("out_byte", want.out_byte, out_mon_i.out_byte);
    if (out_mon_i.line_end !== want.line_end)
      report("line_end", want.line_end, out_mon_i.line_end);
    if (out_mon_i.run_last !== want.run_last)
      report("run_last", want.run_last, out_mon_i.run_last);
    if (out_mon_i.distinct_count !== want.distinct_count)
      report("distinct_count", want.distinct_count, out_mon_i.distinct_count);
    if (out_mon_i.table_overflow !== want.table_overflow)
      report("table_overflow", want.table_overflow, out_mon_i.table_overflow);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_code     = BaseCodeRst;
      lead_min      = LeadMinRst;
      held_byte     = '0;
      held_valid    = 1'b0;
      char_count    = 0;
      overflow_seen = 1'b0;
      fails         = 0;
      expected_bytes.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          CfgBaseCode: base_code = cfg_mon_i.data;
          CfgLeadMin:  lead_min  = cfg_mon_i.data;
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_input(in_mon_i.in_byte, in_mon_i.line_last);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output transfer, expected none, actual byte %0d",
                   $time, out_mon_i.out_byte);
          fails++;
        end else begin
          check_byte(expected_bytes.pop_front());
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_bytes.size();
    end
  end

endmodule

[dv/double_byte_char_remapper_tb.sv]
`timescale 1ns / 1ps
// Top of the double-byte character remapper testbench: clock, reset, stimulus and verdict.
// Depends on dbcr_pkg, dbcr_if, double_byte_char_remapper and dbcr_checker.

module double_byte_char_remapper_tb;
  import dbcr_pkg::*;

  localparam int unsigned TableEntries = 64;
  // Far above the slowest correct run, including the long output hold-off.
  localparam int unsigned CycleLimit   = 200000;
  // Length of the output hold-off, long enough to fill the internal queue.
  localparam int unsigned HoldCycles   = 150;
  // Extra wait after the last predicted byte has come out, before the next phase.
  localparam int unsigned DrainCycles  = 8;
  // Register indexes that map to nothing; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dbcr_in_if  in_if ();
  dbcr_out_if out_if ();
  dbcr_cfg_if cfg_if ();

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;

  // Random idling on both sides is switched on per phase.
  logic       gaps_on  = 1'b0;
  // Set once by the stimulus to make the receiver hold off for a long stretch.
  logic       hold_req = 1'b0;
  // The stimulus keeps its own copy of lead_min to shape pairs and plain bytes.
  logic [7:0] cur_lead = LeadMinRst;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  double_byte_char_remapper #(
    .TABLE_ENTRIES(TableEntries)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  dbcr_checker #(
    .TABLE_ENTRIES(TableEntries)
  ) remap_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon_i    (in_if),
    .out_mon_i   (out_if),
    .cfg_mon_i   (cfg_if),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  // Watchdog: a hang or a result that never comes ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver. Outside the hold-off it raises ready about 70 percent of the time
  // when idling is on, and always otherwise. The hold-off is counted here.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done     = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_if.ready <= !gaps_on || ($urandom_range(99) >= 30);
    end
  end

  // Offers one byte and returns at the edge where it is transferred. Valid stays
  // high so that the next byte can follow back to back; an idle gap lowers it first.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gaps_on && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.in_byte   <= b;
    in_if.line_last <= last;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Raises the write channel and waits for its transfer. The caller lowers valid
  // after the last write of a group, so valid is never dropped and raised in one step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic set_config(input logic [7:0] base, input logic [7:0] lead);
    write_reg(CfgBaseCode, base);
    write_reg(CfgLeadMin, lead);
    cfg_if.valid <= 1'b0;
    cur_lead = lead;
  endtask

  // Stops offering bytes and waits until every predicted byte has come out. The
  // first edge lets the scoreboard count the bytes of the last transfer. Every
  // phase ends its last line, so no lead byte is left waiting for a partner, and a
  // pair still in the lookup counts as pending; the extra cycles follow after that.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Random text made of lines of 1 to 12 bytes. Most of each line is well-formed:
  // double-byte characters from a narrow alphabet just above lead_min, so that
  // characters repeat and hit the table, and plain bytes below lead_min. The rest
  // is noise: any byte value, which may be a lone lead byte that shifts the pairing.
  task automatic send_text(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned len;
    int unsigned pos;
    int unsigned roll;
    int unsigned span;
    logic [7:0]  hi;
    logic [7:0]  lo;
    sent = 0;
    span = (255 - cur_lead < 7) ? 255 - cur_lead : 7;
    while (sent < n_bytes) begin
      len = $urandom_range(12, 1);
      pos = 0;
      while (pos < len) begin
        roll = $urandom_range(99);
        if (roll < 55 && pos + 2 <= len) begin
          if ($urandom_range(99) < 85) begin
            hi = cur_lead + $urandom_range(span);
            lo = cur_lead + $urandom_range(span);
          end else begin
            hi = $urandom_range(255, cur_lead);
            lo = $urandom_range(255, cur_lead);
          end
          send_byte(hi, 1'b0);
          send_byte(lo, pos + 2 == len);
          pos += 2;
        end else if (roll < 85) begin
          send_byte($urandom_range(cur_lead - 1), pos + 1 == len);
          pos += 1;
        end else begin
          send_byte($urandom_range(255), pos + 1 == len);
          pos += 1;
        end
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    in_if.valid     <= 1'b0;
    in_if.in_byte   <= '0;
    in_if.line_last <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings (base 128, lead_min 0xA1), no idling.
    send_byte(8'h00, 1'b0);   // lowest byte passes through
    send_byte(8'hFF, 1'b1);   // a lead byte that ends its line is never held
    send_byte(8'hA1, 1'b0);   // pair at exactly lead_min, new character in slot 0
    send_byte(8'hA1, 1'b0);
    send_byte(8'hB0, 1'b0);   // second character, slot 1, ends the line
    send_byte(8'hC0, 1'b1);
    send_byte(8'hA1, 1'b0);   // repeat of slot 0 hits the table
    send_byte(8'hA1, 1'b0);
    send_byte(8'hA0, 1'b0);   // one below lead_min passes through
    send_byte(8'hC5, 1'b0);   // held byte followed by a plain byte: both pass
    send_byte(8'h41, 1'b0);
    send_byte(8'hC5, 1'b0);   // pair whose second byte ends the line, slot 2
    send_byte(8'hD0, 1'b1);
    send_byte(8'hE0, 1'b0);   // held byte, then a plain byte that ends the line
    send_byte(8'h0A, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();

    // Writes to unused indexes must change nothing. Then base 250 puts slot 3 out
    // of code range: the new character is stored but passes through and sets the
    // overflow flag, while slot 0 still maps to 250 and 251.
    write_reg(CfgSpareLo, $urandom_range(255));
    write_reg(CfgSpareHi, $urandom_range(255));
    set_config(8'd250, 8'hA1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hF1, 1'b0);
    send_byte(8'hA1, 1'b0);
    send_byte(8'hA1, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain();

    // Long stretch without idling at the reset values. Each narrow alphabet holds
    // 64 characters, so with the phases that follow the table fills and new
    // characters start to overflow.
    set_config(BaseCodeRst, LeadMinRst);
    send_text(200);
    drain();

    // Lowest base and lead_min 128, idling on both sides, and the long
    // hold-off on the output while bytes keep coming until the input stalls.
    set_config(8'd0, 8'd128);
    gaps_on  <= 1'b1;
    hold_req <= 1'b1;
    send_text(200);
    drain();

    // Highest values: only 0xFF pairs, and every code is out of range.
    set_config(8'd255, 8'd255);
    send_text(150);
    drain();

    // lead_min below 128 is used as written.
    set_config(8'd64, 8'd100);
    send_text(150);
    drain();

    set_config(8'd200, 8'd200);
    send_text(230);
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/dbcr_pkg.sv
sv/dbcr_if.sv
sv/dbcr_front.sv
sv/dbcr_queue.sv
sv/dbcr_back.sv
sv/double_byte_char_remapper.sv
dv/dbcr_checker.sv
dv/double_byte_char_remapper_tb.sv
